[sv/idrd_pkg.sv]
package idrd_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int ID_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_CONTAINS  = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_FORWARD   = 3'd3,
        OP_BACKWARD  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_NOT_TRANSLATED = 3'd1,
        ST_UNKNOWN        = 3'd2,
        ST_LATE_INSERT    = 3'd3,
        ST_FULL           = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RESOLVE,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic cmp;
        logic load;
        logic shift;
        logic wr;
    } cell_ctl_t;

    typedef struct packed {
        logic hit;
        logic mhit;
        logic rhit;
    } cell_hit_t;

endpackage

[sv/idrd_if.sv]
interface idrd_req_if import idrd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [KEY_W-1:0]  key;
    logic [RANK_W-1:0]        rank;

    modport source (output valid, operation, key, rank, input ready);
    modport sink   (input valid, operation, key, rank, output ready);
endinterface

interface idrd_rsp_if import idrd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [KEY_W-1:0]  id_out;
    logic [RANK_W-1:0]        rank_out;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       stored_count;
    logic                     is_translated;

    modport source (output valid, found, id_out, rank_out, status, stored_count,
                    is_translated, input ready);
    modport sink   (input valid, found, id_out, rank_out, status, stored_count,
                    is_translated, output ready);
endinterface

[sv/id_rank_dictionary_core.sv]
// channel  | dir | word
// req      | in  | operation, key, rank
// rsp      | out | found, id_out, rank_out, status, stored_count, is_translated
//
// a result is registered once its word has passed the cell compare and then the resolve state
// with rsp ready a new word is taken only after the previous result has been handed over
// the first translate then circulates ids around the cell ring
// before the next word, each cell counting the mapped ids below its own
// req is taken only when idle with the result register empty; rsp stalls hold it
// reset empties the table at once
module id_rank_dictionary_core
    import idrd_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    idrd_req_if.sink    req,
    idrd_rsp_if.source  rsp
);

    localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                     state_reg, state_next;
    logic [OP_W-1:0]            op_reg;
    logic signed [ID_WIDTH-1:0] key_reg;
    logic [RANK_W-1:0]          want_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       tr_reg, tr_next;
    logic [RW-1:0]              sh_cnt_reg, sh_cnt_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg, found_next;
    logic signed [KEY_W-1:0]    id_o_reg, id_o_next;
    logic [RANK_W-1:0]          rank_o_reg, rank_o_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic [COUNT_W-1:0]         cnt_o_reg, cnt_o_next;
    logic                       tr_o_reg, tr_o_next;

    logic                       accept;
    logic                       do_cmp, do_load, do_shift, do_wr;
    logic                       any_hit, any_mhit, any_rhit;
    logic [RW-1:0]              sel_rank;
    logic signed [ID_WIDTH-1:0] sel_id;

    cell_ctl_t                  ctl_w [DEPTH];
    cell_hit_t                  hits_w [DEPTH];
    logic signed [ID_WIDTH-1:0] circ_id_w [DEPTH];
    logic                       circ_m_w [DEPTH];
    logic signed [ID_WIDTH-1:0] cid_w [DEPTH];
    logic [RW-1:0]              crank_w [DEPTH];

    assign accept = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (op_reg == OP_TRANSLATE && !tr_reg && DEPTH > 1)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (sh_cnt_reg == RW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready = 1'b0;
        do_cmp    = 1'b0;
        do_shift  = 1'b0;
        case (state_reg)
            S_IDLE:    req.ready = !out_valid_reg;
            S_CMP:     do_cmp    = 1'b1;
            S_SHIFT:   do_shift  = 1'b1;
            S_RESOLVE: ;
            default:   ;
        endcase
    end

    // or-reduce the registered cell hits
    always_comb
    begin
        any_hit  = 1'b0;
        any_mhit = 1'b0;
        any_rhit = 1'b0;
        sel_rank = '0;
        sel_id   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            any_hit  = any_hit  | hits_w[i].hit;
            any_mhit = any_mhit | hits_w[i].mhit;
            any_rhit = any_rhit | hits_w[i].rhit;
            sel_rank = sel_rank | (crank_w[i] & {RW{hits_w[i].mhit}});
            sel_id   = sel_id   | (cid_w[i] & {ID_WIDTH{hits_w[i].rhit}});
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        tr_next        = tr_reg;
        sh_cnt_next    = sh_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        id_o_next      = id_o_reg;
        rank_o_next    = rank_o_reg;
        status_next    = status_reg;
        cnt_o_next     = cnt_o_reg;
        tr_o_next      = tr_o_reg;
        do_load        = 1'b0;
        do_wr          = 1'b0;
        if (state_reg == S_SHIFT)
        begin
            sh_cnt_next = sh_cnt_reg - RW'(1);
        end
        if (state_reg == S_RESOLVE)
        begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            id_o_next      = '0;
            rank_o_next    = '0;
            status_next    = ST_OK;
            case (op_reg)
                OP_INSERT:
                begin
                    if (any_hit)
                    begin
                        found_next = 1'b1;
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        do_wr      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        found_next = 1'b1;
                        if (tr_reg)
                        begin
                            status_next = ST_LATE_INSERT;
                        end
                    end
                end
                OP_CONTAINS:
                begin
                    found_next  = any_hit;
                    status_next = any_hit ? ST_OK : ST_UNKNOWN;
                end
                OP_TRANSLATE:
                begin
                    found_next = 1'b1;
                    if (!tr_reg)
                    begin
                        do_load     = 1'b1;
                        tr_next     = 1'b1;
                        sh_cnt_next = RW'(DEPTH - 1);
                    end
                end
                OP_FORWARD:
                begin
                    if (!tr_reg)
                    begin
                        status_next = ST_NOT_TRANSLATED;
                    end
                    else if (any_mhit)
                    begin
                        found_next  = 1'b1;
                        rank_o_next = RANK_W'(sel_rank);
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                    end
                end
                OP_BACKWARD:
                begin
                    if (!tr_reg)
                    begin
                        status_next = ST_NOT_TRANSLATED;
                    end
                    else if (any_rhit)
                    begin
                        found_next = 1'b1;
                        id_o_next  = KEY_W'(sel_id);
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                    end
                end
                default: ;
            endcase
            cnt_o_next = COUNT_W'(count_next);
            tr_o_next  = tr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tr_reg        <= 1'b0;
            sh_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tr_reg        <= tr_next;
            sh_cnt_reg    <= sh_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            key_reg  <= ID_WIDTH'(req.key);
            want_reg <= req.rank;
        end
        found_reg  <= found_next;
        id_o_reg   <= id_o_next;
        rank_o_reg <= rank_o_next;
        status_reg <= status_next;
        cnt_o_reg  <= cnt_o_next;
        tr_o_reg   <= tr_o_next;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        assign ctl_w[g].cmp   = do_cmp;
        assign ctl_w[g].load  = do_load;
        assign ctl_w[g].shift = do_shift;
        assign ctl_w[g].wr    = do_wr && (count_reg[RW-1:0] == RW'(g));

        idrd_cell #(
            .DEPTH    (DEPTH),
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl_w[g]),
            .key_id      (key_reg),
            .want        (want_reg),
            .circ_id_in  (circ_id_w[(g == 0) ? DEPTH - 1 : g - 1]),
            .circ_m_in   (circ_m_w[(g == 0) ? DEPTH - 1 : g - 1]),
            .circ_id_out (circ_id_w[g]),
            .circ_m_out  (circ_m_w[g]),
            .hits        (hits_w[g]),
            .id_out      (cid_w[g]),
            .rank_out    (crank_w[g])
        );
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.id_out        = id_o_reg;
    assign rsp.rank_out      = rank_o_reg;
    assign rsp.status        = status_reg;
    assign rsp.stored_count  = cnt_o_reg;
    assign rsp.is_translated = tr_o_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_shift_after_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> tr_reg)
        else $error("ring shift without translate");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CMP)
        else $error("accepted word not compared");

    a_freeze_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tr_reg) |-> $past(state_reg == S_RESOLVE && op_reg == OP_TRANSLATE))
        else $error("translate flag set outside translate");

    a_ready_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid && state_reg == S_IDLE)
        else $error("request taken while result pending");
`endif

endmodule

[sv/idrd_cell.sv]
module idrd_cell
    import idrd_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctl_t                  ctl,
    input  logic signed [ID_WIDTH-1:0] key_id,
    input  logic [RANK_W-1:0]          want,
    input  logic signed [ID_WIDTH-1:0] circ_id_in,
    input  logic                       circ_m_in,
    output logic signed [ID_WIDTH-1:0] circ_id_out,
    output logic                       circ_m_out,
    output cell_hit_t                  hits,
    output logic signed [ID_WIDTH-1:0] id_out,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rank_out
);

    localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (RW > RANK_W) ? RW : RANK_W;

    logic signed [ID_WIDTH-1:0] id_reg, id_next;
    logic signed [ID_WIDTH-1:0] circ_id_reg, circ_id_next;
    logic                       valid_reg, valid_next;
    logic                       mapped_reg, mapped_next;
    logic                       circ_m_reg, circ_m_next;
    logic [RW-1:0]              rank_reg, rank_next;
    cell_hit_t                  hits_reg, hits_next;
    logic                       key_eq;

    assign key_eq = valid_reg && (id_reg == key_id);

    always_comb
    begin
        id_next      = id_reg;
        circ_id_next = circ_id_reg;
        valid_next   = valid_reg;
        mapped_next  = mapped_reg;
        circ_m_next  = circ_m_reg;
        rank_next    = rank_reg;
        hits_next    = hits_reg;
        if (ctl.cmp)
        begin
            hits_next.hit  = key_eq;
            hits_next.mhit = key_eq && mapped_reg;
            hits_next.rhit = mapped_reg && (CW'(rank_reg) == CW'(want));
        end
        if (ctl.wr)
        begin
            id_next     = key_id;
            valid_next  = 1'b1;
            mapped_next = 1'b0;
        end
        if (ctl.load)
        begin
            mapped_next  = valid_reg;
            circ_m_next  = valid_reg;
            circ_id_next = id_reg;
            rank_next    = '0;
        end
        if (ctl.shift)
        begin
            circ_id_next = circ_id_in;
            circ_m_next  = circ_m_in;
            if (circ_m_in && (circ_id_in < id_reg))
            begin
                rank_next = rank_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            mapped_reg <= 1'b0;
            circ_m_reg <= 1'b0;
            rank_reg   <= '0;
            hits_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            mapped_reg <= mapped_next;
            circ_m_reg <= circ_m_next;
            rank_reg   <= rank_next;
            hits_reg   <= hits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        circ_id_reg <= circ_id_next;
    end

    assign circ_id_out = circ_id_reg;
    assign circ_m_out  = circ_m_reg;
    assign hits        = hits_reg;
    assign id_out      = id_reg;
    assign rank_out    = rank_reg;

endmodule

[sim/id_rank_dictionary_core_test.sv]
module id_rank_dictionary_core_test
    import idrd_pkg::*;
;

    localparam int WORD_TOTAL   = 1900;
    localparam int PRE_RANDOM   = 50;
    localparam int PHASE_LEN    = 97;
    localparam int IDLE_PCT     = 61;
    localparam int BOTH_PCT     = 24;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = DEPTH_DEF + 8;
    localparam int RUN_LIMIT    = 2000000;
    localparam int PRINT_CAP    = 40;

    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    typedef struct {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] key;
        logic [RANK_W-1:0]       rank;
    } req_word_t;

    typedef struct {
        logic                    found;
        logic signed [KEY_W-1:0] id_out;
        logic [RANK_W-1:0]       rank_out;
        status_t                 status;
        logic [COUNT_W-1:0]      stored_count;
        logic                    is_translated;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    idrd_req_if req ();
    idrd_rsp_if rsp ();

    id_rank_dictionary_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // predictor copy of the dictionary
    logic signed [KEY_W-1:0] table_ids    [DEPTH_DEF];
    logic                    table_valid  [DEPTH_DEF];
    logic                    table_mapped [DEPTH_DEF];
    logic                    table_frozen;
    int                      table_count;

    req_word_t outgoing_words [$];
    answer_t   pending_answers [$];

    logic req_taken;
    logic rsp_hold;
    int   words_in;
    int   results_seen;
    int   error_count;
    int   status_tally [0:4];
    int   frozen_ids;

    always #5 clk = ~clk;

    function automatic int find_entry(logic signed [KEY_W-1:0] id);
        for (int i = 0; i < DEPTH_DEF; i++)
        begin
            if (table_valid[i] && table_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic int mapped_below(logic signed [KEY_W-1:0] id);
        int n;
        n = 0;
        for (int i = 0; i < DEPTH_DEF; i++)
        begin
            if (table_valid[i] && table_mapped[i] && table_ids[i] < id)
                n++;
        end
        return n;
    endfunction

    function automatic answer_t dictionary_answer(req_word_t w);
        answer_t a;
        int      hit;
        a.found    = 1'b0;
        a.id_out   = '0;
        a.rank_out = '0;
        a.status   = ST_OK;
        case (w.operation)
            OP_INSERT:
            begin
                hit = find_entry(w.key);
                if (hit >= 0)
                    a.found = 1'b1;
                else if (table_count >= DEPTH_DEF)
                    a.status = ST_FULL;
                else
                begin
                    table_ids[table_count]    = w.key;
                    table_valid[table_count]  = 1'b1;
                    table_mapped[table_count] = 1'b0;
                    table_count++;
                    a.found = 1'b1;
                    if (table_frozen)
                        a.status = ST_LATE_INSERT;
                end
            end
            OP_CONTAINS:
            begin
                if (find_entry(w.key) >= 0)
                    a.found = 1'b1;
                else
                    a.status = ST_UNKNOWN;
            end
            OP_TRANSLATE:
            begin
                if (!table_frozen)
                begin
                    for (int i = 0; i < DEPTH_DEF; i++)
                        table_mapped[i] = table_valid[i];
                    table_frozen = 1'b1;
                    frozen_ids   = table_count;
                end
                a.found = 1'b1;
            end
            OP_FORWARD:
            begin
                if (!table_frozen)
                    a.status = ST_NOT_TRANSLATED;
                else
                begin
                    hit = find_entry(w.key);
                    if (hit >= 0 && table_mapped[hit])
                    begin
                        a.found    = 1'b1;
                        a.rank_out = RANK_W'(mapped_below(w.key));
                    end
                    else
                        a.status = ST_UNKNOWN;
                end
            end
            OP_BACKWARD:
            begin
                if (!table_frozen)
                    a.status = ST_NOT_TRANSLATED;
                else
                begin
                    a.status = ST_UNKNOWN;
                    for (int i = 0; i < DEPTH_DEF; i++)
                    begin
                        if (!a.found && table_valid[i] && table_mapped[i]
                            && mapped_below(table_ids[i]) == int'(w.rank))
                        begin
                            a.found  = 1'b1;
                            a.id_out = table_ids[i];
                            a.status = ST_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        a.stored_count  = COUNT_W'(table_count);
        a.is_translated = table_frozen;
        return a;
    endfunction

    function automatic phase_t idle_phase();
        return phase_t'((words_in / PHASE_LEN) % 4);
    endfunction

    function automatic bit sender_waits();
        if (rsp_hold)
            return 1'b0;
        case (idle_phase())
            PH_SEND_IDLE: return $urandom_range(99, 0) < IDLE_PCT;
            PH_BOTH:      return $urandom_range(99, 0) < BOTH_PCT;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_waits();
        if (rsp_hold)
            return 1'b1;
        case (idle_phase())
            PH_RECV_STALL: return $urandom_range(99, 0) < IDLE_PCT;
            PH_BOTH:       return $urandom_range(99, 0) < BOTH_PCT;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        if (error_count < PRINT_CAP)
            $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got,
                     want);
        error_count++;
    endtask

    // driver
    always @(negedge clk)
    begin : drive_words
        req_word_t w;
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.operation <= '0;
            req.key       <= '0;
            req.rank      <= '0;
            rsp.ready     <= 1'b0;
        end
        else
        begin
            if (!req.valid || req_taken)
            begin
                if (outgoing_words.size() != 0 && !sender_waits())
                begin
                    w = outgoing_words.pop_front();
                    req.valid     <= 1'b1;
                    req.operation <= w.operation;
                    req.key       <= w.key;
                    req.rank      <= w.rank;
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= !receiver_waits();
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : watch_words
        answer_t   want;
        answer_t   expected;
        req_word_t w;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            table_frozen = 1'b0;
            table_count  = 0;
            for (int i = 0; i < DEPTH_DEF; i++)
            begin
                table_ids[i]    = '0;
                table_valid[i]  = 1'b0;
                table_mapped[i] = 1'b0;
            end
        end
        else
        begin
            req_taken <= req.valid && req.ready;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("unexpected word", {31'b0, rsp.found}, '0);
                else
                begin
                    want = pending_answers.pop_front();
                    status_tally[want.status]++;
                    if (rsp.found !== want.found)
                        report_mismatch("found", KEY_W'(rsp.found), KEY_W'(want.found));
                    if (rsp.id_out !== want.id_out)
                        report_mismatch("id_out", rsp.id_out, want.id_out);
                    if (rsp.rank_out !== want.rank_out)
                        report_mismatch("rank_out", KEY_W'(rsp.rank_out), KEY_W'(want.rank_out));
                    if (rsp.status !== want.status)
                        report_mismatch("status", KEY_W'(rsp.status), KEY_W'(want.status));
                    if (rsp.stored_count !== want.stored_count)
                        report_mismatch("stored_count", KEY_W'(rsp.stored_count),
                                        KEY_W'(want.stored_count));
                    if (rsp.is_translated !== want.is_translated)
                        report_mismatch("is_translated", KEY_W'(rsp.is_translated),
                                        KEY_W'(want.is_translated));
                end
                results_seen++;
            end
            if (req.valid && req.ready)
            begin
                w.operation = req.operation;
                w.key       = req.key;
                w.rank      = req.rank;
                expected    = dictionary_answer(w);
                pending_answers = {pending_answers, expected};
                words_in++;
            end
        end
    end

    // long receiver hold-off so the block backs up into the request side
    initial
    begin
        rsp_hold = 1'b0;
        while (words_in < HOLD_AT)
            @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("id_rank_dictionary_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [KEY_W-1:0] issued_keys [$];
        bit                      key_seen [int];
        int                      pick;
        int                      mapped_guess;
        logic signed [KEY_W-1:0] k;

        rst_n = 1'b0;

        // lookups before anything is stored or frozen
        queue_word(OP_FORWARD, '0, '0);
        queue_word(OP_BACKWARD, '0, '0);
        queue_word(OP_BACKWARD, '0, '1);
        queue_word(OP_CONTAINS, '0, '0);
        // extreme and patterned ids, then a duplicate
        queue_word(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, '0);
        queue_word(OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        queue_word(OP_INSERT, '0, '0);
        queue_word(OP_INSERT, '1, '0);
        queue_word(OP_INSERT, KEY_W'(1), '0);
        queue_word(OP_INSERT, {(KEY_W/2){2'b01}}, '0);
        queue_word(OP_INSERT, {(KEY_W/2){2'b10}}, '0);
        queue_word(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, '0);
        queue_word(OP_CONTAINS, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        queue_word(OP_CONTAINS, KEY_W'(2), '0);
        queue_word(OP_FORWARD, '1, '0);
        queue_word(OP_RESERVED_LO, $urandom, RANK_W'($urandom));
        queue_word(OP_RESERVED_LO + 3'd1, $urandom, RANK_W'($urandom));
        queue_word(OP_RESERVED_HI, $urandom, RANK_W'($urandom));
        issued_keys = '{{1'b1, {(KEY_W-1){1'b0}}}, {1'b0, {(KEY_W-1){1'b1}}}, '0, '1,
                        KEY_W'(1), {(KEY_W/2){2'b01}}, {(KEY_W/2){2'b10}}};
        foreach (issued_keys[i])
            key_seen[int'(issued_keys[i])] = 1'b1;

        // filling the set before the freeze
        for (int n = 0; n < PRE_RANDOM; n++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
            begin
                k = ($urandom_range(99, 0) < 85) ? fresh_key()
                    : issued_keys[$urandom_range(issued_keys.size() - 1, 0)];
                if (!key_seen.exists(int'(k)))
                begin
                    key_seen[int'(k)] = 1'b1;
                    issued_keys = {issued_keys, k};
                end
                queue_word(OP_INSERT, k, RANK_W'($urandom));
            end
            else if (pick < 85)
                queue_word(OP_CONTAINS, $urandom_range(1, 0) ? fresh_key()
                           : issued_keys[$urandom_range(issued_keys.size() - 1, 0)],
                           RANK_W'($urandom));
            else if (pick < 95)
                queue_word($urandom_range(1, 0) ? OP_FORWARD : OP_BACKWARD,
                           issued_keys[$urandom_range(issued_keys.size() - 1, 0)],
                           RANK_W'($urandom));
            else
                queue_word(OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)), $urandom,
                           RANK_W'($urandom));
        end
        mapped_guess = issued_keys.size();

        // freeze, repeat it, and probe the ends of the rank range
        queue_word(OP_TRANSLATE, $urandom, RANK_W'($urandom));
        queue_word(OP_TRANSLATE, $urandom, RANK_W'($urandom));
        queue_word(OP_FORWARD, {1'b1, {(KEY_W-1){1'b0}}}, '0);
        queue_word(OP_FORWARD, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        queue_word(OP_BACKWARD, '0, '0);
        queue_word(OP_BACKWARD, '0, '1);

        while (outgoing_words.size() < WORD_TOTAL)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 10)
            begin
                k = ($urandom_range(99, 0) < 80) ? fresh_key()
                    : issued_keys[$urandom_range(issued_keys.size() - 1, 0)];
                if (!key_seen.exists(int'(k)))
                begin
                    key_seen[int'(k)] = 1'b1;
                    issued_keys = {issued_keys, k};
                end
                queue_word(OP_INSERT, k, RANK_W'($urandom));
            end
            else if (pick < 28)
                queue_word(OP_CONTAINS, ($urandom_range(99, 0) < 70)
                           ? issued_keys[$urandom_range(issued_keys.size() - 1, 0)]
                           : fresh_key(), RANK_W'($urandom));
            else if (pick < 58)
                queue_word(OP_FORWARD, ($urandom_range(99, 0) < 75)
                           ? issued_keys[$urandom_range(issued_keys.size() - 1, 0)]
                           : fresh_key(), RANK_W'($urandom));
            else if (pick < 90)
                queue_word(OP_BACKWARD, $urandom, ($urandom_range(3, 0) == 0)
                           ? RANK_W'($urandom)
                           : RANK_W'($urandom_range((mapped_guess > 63) ? 63 : mapped_guess,
                                                    0)));
            else if (pick < 94)
                queue_word(OP_TRANSLATE, $urandom, RANK_W'($urandom));
            else
                queue_word(OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)), $urandom,
                           RANK_W'($urandom));
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (outgoing_words.size() != 0 || req.valid)
            @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d results from %0d words: ok %0d, not translated %0d, unknown %0d",
                 results_seen, words_in, status_tally[ST_OK],
                 status_tally[ST_NOT_TRANSLATED], status_tally[ST_UNKNOWN]);
        $display("late inserts %0d, full rejects %0d, %0d ids frozen, %0d-cycle receiver hold",
                 status_tally[ST_LATE_INSERT], status_tally[ST_FULL], frozen_ids, HOLD_CYCLES);
        if (error_count == 0)
            $display("id_rank_dictionary_core test passed");
        else
            $display("id_rank_dictionary_core test failed");
        $finish;
    end

    function automatic logic signed [KEY_W-1:0] fresh_key();
        case ($urandom_range(3, 0))
            0:       return KEY_W'($urandom_range(16, 0) - 8);
            1:       return {1'b1, (KEY_W-1)'($urandom_range(15, 0))};
            2:       return {1'b0, ~(KEY_W-1)'($urandom_range(15, 0))};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input logic [OP_W-1:0] operation,
                              input logic signed [KEY_W-1:0] key,
                              input logic [RANK_W-1:0] rank);
        req_word_t w;
        w.operation = operation;
        w.key       = key;
        w.rank      = rank;
        outgoing_words = {outgoing_words, w};
    endtask

endmodule
